/* rtl/bmsc_pkg.sv */
// ----------------------------------------------------------------------------
// bmsc_pkg
// Shared types and constants of the bit map with set, clear and find-first.
// ----------------------------------------------------------------------------
package bmsc_pkg;

    // Field widths of the stream and configuration ports
    localparam int KIND_W      = 3;
    localparam int IDX_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // Bit position arithmetic (size plus one word still fits)
    localparam int BASE_W = 12;

    // Map size after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Request kinds carried on s_axis_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_SET        = 3'd0,
        KIND_CLEAR      = 3'd1,
        KIND_TEST       = 3'd2,
        KIND_CLEAR_ALL  = 3'd3,
        KIND_FIND_SET   = 3'd4,
        KIND_FIND_CLEAR = 3'd5
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_ADDR,
        ST_LOOK,
        ST_FIN
    } t_state;

endpackage

/* rtl/bmsc_word_scan.sv */
// ----------------------------------------------------------------------------
// bmsc_word_scan
// Finds the lowest matching bit of one map word between a start offset and
// the number of bits still in range. Shared by every step of a search.
// ----------------------------------------------------------------------------
module bmsc_word_scan #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]         i_word,
    input  logic                         i_invert,   // look for clear bits
    input  logic [$clog2(WORD_BITS)-1:0] i_start,
    input  logic [bmsc_pkg::BASE_W-1:0]  i_limit,    // bits of this word in range
    output logic                         o_hit,
    output logic [$clog2(WORD_BITS)-1:0] o_pos
);
    import bmsc_pkg::*;

    localparam int OW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] iso;

    // Candidate bits: matching value, at or after start, below the size
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            cand[j] = (i_word[j] ^ i_invert) && (OW'(j) >= i_start) &&
                      (BASE_W'(j) < i_limit);
        end
    end

    // Isolate the lowest candidate and encode its position
    assign iso   = cand & (~cand + {{(WORD_BITS-1){1'b0}}, 1'b1});
    assign o_hit = |cand;

    always_comb begin
        o_pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (iso[j]) begin
                o_pos = o_pos | OW'(j);
            end
        end
    end

endmodule

/* rtl/bitmap_set_clear_find_first.sv */
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_first: bit map with set/clear/test/clear-all/find-first
// Set, clear and test pass ST_SPLIT, ST_ADDR, ST_LOOK, ST_FIN from request
// transfer to result valid; searches stay in ST_LOOK for each word scanned
// (one map word per cycle through the shared word scan unit, up to 16 words);
// clear-all, bad index and unused kinds go straight to ST_FIN, which waits while
// the result stalls. One request at a time; the next is taken back in ST_IDLE.
// Reset: count and word valid bits cleared (map reads as empty), size 1024.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find_first #(
    parameter int MAP_BITS  = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bmsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] bit_index
    input  logic [bmsc_pkg::KIND_W-1:0]      s_axis_tuser,   // [2:0] kind
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] bit_was_set, [1] found, [11:2] found_index, [22:12] set_count,
    // [23] any_set, [24] any_clear, [25] index_error
    output logic [bmsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Size register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bmsc_pkg::SIZE_W-1:0]      i_cfg_data
);
    import bmsc_pkg::*;

    localparam int SZ_CAP     = (MAP_BITS > 2047) ? 2047 : MAP_BITS;
    localparam int MEM_BITS   = (MAP_BITS > 1024) ? 1024 : MAP_BITS;
    localparam int MEM_WORDS  = (MEM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int SCAN_WORDS = (SZ_CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int WW         = (SCAN_WORDS > 1) ? $clog2(SCAN_WORDS) : 1;
    localparam int MA         = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int OW         = $clog2(WORD_BITS);
    localparam int RECIP_SH   = 16;
    localparam int RECIP      = (1 << RECIP_SH) / WORD_BITS;
    localparam int PW         = IDX_W + RECIP_SH + 1;

    // Sequencer and request registers
    t_state                r_state, n_state;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [WW-1:0]         r_word, n_word;
    logic [BASE_W-1:0]     r_base, n_base;
    logic [OW-1:0]         r_off, n_off;
    logic                  r_first, n_first;
    logic                  r_was, n_was;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_fidx, n_fidx;
    logic                  r_err, n_err;
    // Map state
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [SIZE_W-1:0]     r_count, n_count;
    logic [MEM_WORDS-1:0]  r_vld, n_vld;
    logic [WORD_BITS-1:0]  mem [MEM_WORDS];
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_rd_vld;
    // Output register
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [SIZE_W-1:0]     eff_size;
    logic [IDX_W-1:0]      in_idx;
    logic                  in_range;
    logic [PW-1:0]         prod;
    logic [BASE_W-1:0]     base0;
    logic [BASE_W-1:0]     rem;
    logic                  rem_fix;
    logic [BASE_W-1:0]     limit;
    logic [BASE_W-1:0]     next_base;
    logic                  more;
    logic [WORD_BITS-1:0]  word_now;
    logic                  bit_now;
    logic [WORD_BITS-1:0]  onehot;
    logic                  scan_hit;
    logic [OW-1:0]         scan_pos;
    logic [WW-1:0]         rd_addr;
    logic                  mem_we;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic                  load_out;
    logic                  any_set;
    logic                  any_clear;

    // Effective size and input range check
    assign eff_size = (r_size > SIZE_W'(SZ_CAP)) ? SIZE_W'(SZ_CAP) : r_size;
    assign in_idx   = s_axis_tdata[IDX_W-1:0];
    assign in_range = {1'b0, in_idx} < eff_size;

    // Word index estimate by reciprocal, corrected in the next step
    assign prod    = PW'(r_idx) * PW'(RECIP);
    assign base0   = BASE_W'(r_word) * BASE_W'(WORD_BITS);
    assign rem     = BASE_W'(r_idx) - base0;
    assign rem_fix = rem >= BASE_W'(WORD_BITS);

    // Current word and search bounds
    assign word_now  = r_rd_vld ? r_rd_data : '0;
    assign bit_now   = word_now[r_off];
    assign onehot    = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_off;
    assign limit     = BASE_W'(eff_size) - r_base;
    assign next_base = r_base + BASE_W'(WORD_BITS);
    assign more      = next_base < BASE_W'(eff_size);

    bmsc_word_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .i_word   (word_now),
        .i_invert (r_kind == KIND_FIND_CLEAR),
        .i_start  (r_off),
        .i_limit  (limit),
        .o_hit    (scan_hit),
        .o_pos    (scan_pos)
    );

    // Handshakes
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE);

    // Next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_word    = r_word;
        n_base    = r_base;
        n_off     = r_off;
        n_first   = r_first;
        n_was     = r_was;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_err     = r_err;
        n_size    = r_size;
        n_count   = r_count;
        n_vld     = r_vld;
        rd_addr   = r_word;
        mem_we    = 1'b0;
        mem_wdata = word_now;
        load_out  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_kind  = s_axis_tuser;
                    n_idx   = in_idx;
                    n_was   = 1'b0;
                    n_found = 1'b0;
                    n_fidx  = '0;
                    n_err   = 1'b0;
                    n_first = 1'b1;
                    if (s_axis_tuser == KIND_CLEAR_ALL) begin
                        n_vld   = '0;
                        n_count = '0;
                        n_state = ST_FIN;
                    end else if (s_axis_tuser > KIND_FIND_CLEAR) begin
                        n_state = ST_FIN;
                    end else if (!in_range) begin
                        n_err   = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_SPLIT;
                    end
                end else if (i_cfg_valid && o_cfg_ready) begin
                    n_size  = i_cfg_data;
                    n_vld   = '0;
                    n_count = '0;
                end
            end

            ST_SPLIT: begin
                n_word  = WW'(prod >> RECIP_SH);
                n_state = ST_ADDR;
            end

            ST_ADDR: begin
                if (rem_fix) begin
                    n_word = r_word + WW'(1);
                    n_base = base0 + BASE_W'(WORD_BITS);
                    n_off  = OW'(rem - BASE_W'(WORD_BITS));
                end else begin
                    n_base = base0;
                    n_off  = OW'(rem);
                end
                rd_addr = n_word;
                n_state = ST_LOOK;
            end

            ST_LOOK: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_was = bit_now;
                end
                n_state = ST_FIN;
                unique case (r_kind)
                    KIND_SET: begin
                        if (!bit_now) begin
                            mem_we              = 1'b1;
                            mem_wdata           = word_now | onehot;
                            n_vld[r_word[MA-1:0]] = 1'b1;
                            n_count             = r_count + SIZE_W'(1);
                        end
                    end
                    KIND_CLEAR: begin
                        if (bit_now) begin
                            mem_we              = 1'b1;
                            mem_wdata           = word_now & ~onehot;
                            n_vld[r_word[MA-1:0]] = 1'b1;
                            n_count             = r_count - SIZE_W'(1);
                        end
                    end
                    KIND_FIND_SET, KIND_FIND_CLEAR: begin
                        if (scan_hit) begin
                            n_found = 1'b1;
                            n_fidx  = IDX_W'(r_base + BASE_W'(scan_pos));
                        end else if (more) begin
                            // Step to the next word
                            n_word  = r_word + WW'(1);
                            n_base  = next_base;
                            n_off   = '0;
                            rd_addr = r_word + WW'(1);
                            n_state = ST_LOOK;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_size  <= SIZE_RESET;
            r_count <= '0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_count <= n_count;
            r_vld   <= n_vld;
        end
    end

    // Request payload registers
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_idx   <= n_idx;
        r_word  <= n_word;
        r_base  <= n_base;
        r_off   <= n_off;
        r_first <= n_first;
        r_was   <= n_was;
        r_found <= n_found;
        r_fidx  <= n_fidx;
        r_err   <= n_err;
    end

    // Map memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_word[MA-1:0]] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr[MA-1:0]];
        r_rd_vld  <= ({1'b0, rd_addr} < (WW+1)'(MEM_WORDS)) && r_vld[rd_addr[MA-1:0]];
    end

    // Status derived from the count
    assign any_set   = r_count != '0;
    assign any_clear = r_count < eff_size;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {6'b0, r_err, any_clear, any_set, r_count, r_fidx,
                           r_found, r_was};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of bitmap_set_clear_find_first
// Drives set, clear, test, clear-all and find-first requests under several map
// sizes, tracks a shadow copy of the map and its count, and checks every
// result transfer field by field. Both stream sides idle at random. One long
// receiver hold-off backs the block up into its request port.
// ----------------------------------------------------------------------------
module tb;
    import bmsc_pkg::*;

    localparam int MAP_BITS     = 1024;
    localparam int HOLD_AT      = 900;   // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int CALM_FIRST   = 300;   // random items without idling
    localparam int CALM_LAST    = 620;

    // Kinds that the block takes but does nothing with
    localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

    typedef struct packed {
        logic              bit_was_set;
        logic              found;
        logic [IDX_W-1:0]  found_index;
        logic [SIZE_W-1:0] set_count;
        logic              any_set;
        logic              any_clear;
        logic              index_error;
    } t_bitmap_result;

    // Shadow of the map, its count and the size register; holds the results
    // still owed by the block, oldest first
    class bitmap_shadow;
        logic [MAP_BITS-1:0] map_bits;
        int unsigned         set_bits;
        logic [SIZE_W-1:0]   size_setting;
        t_bitmap_result      pending_results[$];
        int unsigned         mismatches;
        int unsigned         results_checked;

        function new();
            map_bits        = '0;
            set_bits        = 0;
            size_setting    = SIZE_RESET;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function int unsigned eff_size();
            return (size_setting > MAP_BITS) ? MAP_BITS : size_setting;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // A size write wipes the map
        function void set_size(logic [SIZE_W-1:0] value);
            size_setting = value;
            map_bits     = '0;
            set_bits     = 0;
        endfunction

        function void accept_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
            t_bitmap_result r;
            int unsigned    eff;
            int unsigned    i;
            r   = '0;
            eff = eff_size();
            if (kind <= KIND_FIND_CLEAR && kind != KIND_CLEAR_ALL && idx >= eff) begin
                r.index_error = 1'b1;
            end else begin
                case (kind)
                    KIND_SET: begin
                        r.bit_was_set = map_bits[idx];
                        if (!map_bits[idx]) begin
                            map_bits[idx] = 1'b1;
                            set_bits++;
                        end
                    end
                    KIND_CLEAR: begin
                        r.bit_was_set = map_bits[idx];
                        if (map_bits[idx]) begin
                            map_bits[idx] = 1'b0;
                            if (set_bits > 0) set_bits--;
                        end
                    end
                    KIND_TEST: begin
                        r.bit_was_set = map_bits[idx];
                    end
                    KIND_CLEAR_ALL: begin
                        map_bits = '0;
                        set_bits = 0;
                    end
                    KIND_FIND_SET, KIND_FIND_CLEAR: begin
                        r.bit_was_set = map_bits[idx];
                        // scan stops at the effective size
                        for (i = idx; i < eff && !r.found; i++) begin
                            if (map_bits[i] == (kind == KIND_FIND_SET)) begin
                                r.found       = 1'b1;
                                r.found_index = IDX_W'(i);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.set_count = SIZE_W'(set_bits);
            r.any_set   = (set_bits != 0);
            r.any_clear = (set_bits < eff);
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            t_bitmap_result want;
            int unsigned    n;
            n = results_checked++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with none owed, tdata %h", n, data));
            end else begin
                want = pending_results.pop_front();
                if (data[0] !== want.bit_was_set)
                    report($sformatf("result %0d bit_was_set %b, want %b",
                                     n, data[0], want.bit_was_set));
                if (data[1] !== want.found)
                    report($sformatf("result %0d found %b, want %b", n, data[1], want.found));
                if (data[11:2] !== want.found_index)
                    report($sformatf("result %0d found_index %0d, want %0d",
                                     n, data[11:2], want.found_index));
                if (data[22:12] !== want.set_count)
                    report($sformatf("result %0d set_count %0d, want %0d",
                                     n, data[22:12], want.set_count));
                if (data[23] !== want.any_set)
                    report($sformatf("result %0d any_set %b, want %b", n, data[23], want.any_set));
                if (data[24] !== want.any_clear)
                    report($sformatf("result %0d any_clear %b, want %b",
                                     n, data[24], want.any_clear));
                if (data[25] !== want.index_error)
                    report($sformatf("result %0d index_error %b, want %b",
                                     n, data[25], want.index_error));
            end
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [SIZE_W-1:0]      i_cfg_data    = '0;

    bitmap_shadow sb = new();
    logic         no_idle = 1'b0;
    int unsigned  results_seen = 0;
    int unsigned  random_sent  = 0;

    bitmap_set_clear_find_first u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // One request transfer; valid stays up afterwards unless the next call idles
    task automatic send_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
        while (!no_idle && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, idx};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.accept_request(kind, idx);
    endtask

    // Size write once every owed result is in
    task automatic write_size(logic [SIZE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_size(value);
    endtask

    // Random requests, about half of them packed into a hot window so that
    // the map gets dense there and searches have runs to cross
    task automatic run_random(int unsigned n_items);
        int unsigned       eff;
        int unsigned       hot_lo;
        int unsigned       hot_n;
        int unsigned       r;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        eff    = sb.eff_size();
        hot_n  = (eff < 128) ? eff : 128;
        hot_lo = (eff > 128) ? $urandom_range(eff - 128) : 0;
        for (int unsigned k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 30)      kind = KIND_SET;
            else if (r < 50) kind = KIND_CLEAR;
            else if (r < 58) kind = KIND_TEST;
            else if (r < 60) kind = KIND_CLEAR_ALL;
            else if (r < 78) kind = KIND_FIND_SET;
            else if (r < 96) kind = KIND_FIND_CLEAR;
            else if (r < 98) kind = KIND_UNUSED_A;
            else             kind = KIND_UNUSED_B;
            r = $urandom_range(99);
            if (eff == 0 || r < 8) idx = IDX_W'($urandom_range(1023));
            else if (r < 60)       idx = IDX_W'(hot_lo + $urandom_range(hot_n - 1));
            else                   idx = IDX_W'($urandom_range(eff - 1));
            if (random_sent == CALM_FIRST) no_idle = 1'b1;
            if (random_sent == CALM_LAST)  no_idle = 1'b0;
            send_request(kind, idx);
            random_sent++;
        end
    endtask

    // Result side: check each transfer, random stalls, one long hold-off
    initial begin
        logic held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                results_seen++;
            end
            if (!held && results_seen == HOLD_AT) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 11);
        end
    end

    // Stimulus
    initial begin
        int unsigned phase_size[10];
        int unsigned phase_items[10];
        phase_size  = '{1, 64, 65, 1024, 130, 0, 1023, 2047, 0, 7};
        phase_items = '{140, 160, 160, 170, 160, 40, 170, 160, 150, 140};
        phase_size[8] = $urandom_range(2047);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full size after reset: edges of the map, repeats, end of search
        send_request(KIND_SET, 10'd0);
        send_request(KIND_SET, 10'd1023);
        send_request(KIND_SET, 10'd0);
        send_request(KIND_TEST, 10'd512);
        send_request(KIND_FIND_SET, 10'd1);
        send_request(KIND_FIND_CLEAR, 10'd0);
        send_request(KIND_CLEAR, 10'd1023);
        send_request(KIND_CLEAR, 10'd1023);
        send_request(KIND_FIND_SET, 10'd1);
        send_request(KIND_UNUSED_A, 10'd1023);
        send_request(KIND_UNUSED_B, 10'd0);
        send_request(KIND_CLEAR_ALL, 10'd1023);
        send_request(KIND_FIND_SET, 10'd0);

        // Tiny map: fill it, then bad indexes
        write_size(11'd2);
        send_request(KIND_SET, 10'd1);
        send_request(KIND_SET, 10'd0);
        send_request(KIND_FIND_CLEAR, 10'd0);
        send_request(KIND_SET, 10'd2);
        send_request(KIND_FIND_SET, 10'd1023);
        send_request(KIND_CLEAR_ALL, 10'd1023);

        // Empty map: every index out of range
        write_size(11'd0);
        send_request(KIND_TEST, 10'd0);
        send_request(KIND_FIND_CLEAR, 10'd0);
        send_request(KIND_CLEAR_ALL, 10'd0);
        send_request(KIND_UNUSED_B, 10'd1023);

        // Size beyond the map clamps to the map
        write_size(11'd2047);
        send_request(KIND_SET, 10'd1023);
        send_request(KIND_FIND_CLEAR, 10'd1023);

        for (int p = 0; p < 10; p++) begin
            write_size(SIZE_W'(phase_size[p]));
            run_random(phase_items[p]);
        end

        // Drain, then watch for stray results
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bmsc_pkg.sv
rtl/bmsc_word_scan.sv
rtl/bitmap_set_clear_find_first.sv
tb/tb.sv
